/* sv/tss_pkg.sv */
package tss_pkg;

    localparam int COORD_BITS = 12;
    localparam int XW         = COORD_BITS + 2;
    localparam int NUM_W      = 2 * COORD_BITS;
    localparam int CNT_W      = $clog2(NUM_W + 1);
    localparam int COLOUR_W   = 16;
    localparam int IN_W       = ((COORD_BITS + 7) / 8) * 8;
    localparam int OUT_FLD_W  = 3 * COORD_BITS + 1 + COLOUR_W;
    localparam int OUT_W      = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int ADDR_W     = 5;
    localparam int REG_IDX_W  = 3;
    localparam int QUEUE_CNT_W = 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_VAX = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VAY = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VBX = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_VBY = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_VCX = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_VCY = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COL = 3'd6;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
    } t_tri;

    // one span job between front and back
    typedef struct packed {
        logic signed [XW-1:0]         base_a;
        logic signed [XW-1:0]         base_b;
        logic [NUM_W-1:0]             num_a;
        logic [NUM_W-1:0]             num_b;
        logic [COORD_BITS-1:0]        den_a;
        logic [COORD_BITS-1:0]        den_b;
        logic                         neg_a;
        logic                         neg_b;
        logic signed [COORD_BITS-1:0] row;
    } t_job;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } t_bstate;

endpackage

/* sv/triangle_scanline_span.sv */
// triangle_scanline_span: filled span of one triangle on a requested row
//
// configure the three vertices and the colour over the apb port, then send
// row numbers on the s_axis channel; each row inside the triangle yields
// one span on m_axis (leftmost x, row, width, colour), rows outside give
// nothing. vertex writes must be done while no row is in flight.
//
// a row is classified and its products for edges a and b formed
// combinationally in the front, then queued (two entries). the back runs
// two restoring dividers, one quotient bit per cycle, one span at a time;
// that divider loop sets the sustained rate. a span passes the
// queue, the back and the output register. rows outside the triangle are
// dropped, taken every cycle that s_axis_tready is high. after each
// register write s_axis_tready drops for one cycle while the sort settles.
//
// reset clears the registers to zero, empties the queue and the output.
// when m_axis stalls the span holds in the output register, the back
// waits with the next result and s_axis keeps accepting until the queue
// fills.
module triangle_scanline_span
    import tss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // apb configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // rows in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // row
    // spans out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata    // span_x, span_row, span_width, span_colour
);

    t_tri                  r_tri;
    logic [COLOUR_W-1:0]   r_colour;
    logic [REG_IDX_W-1:0]  idx;
    logic                  wr;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri    <= '0;
            r_colour <= '0;
        end else if (wr) begin
            case (idx)
                REG_VAX: r_tri.ax <= pwdata[COORD_BITS-1:0];
                REG_VAY: r_tri.ay <= pwdata[COORD_BITS-1:0];
                REG_VBX: r_tri.bx <= pwdata[COORD_BITS-1:0];
                REG_VBY: r_tri.by <= pwdata[COORD_BITS-1:0];
                REG_VCX: r_tri.cx <= pwdata[COORD_BITS-1:0];
                REG_VCY: r_tri.cy <= pwdata[COORD_BITS-1:0];
                REG_COL: r_colour <= pwdata[COLOUR_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (idx)
            REG_VAX: prdata = 32'(unsigned'(r_tri.ax));
            REG_VAY: prdata = 32'(unsigned'(r_tri.ay));
            REG_VBX: prdata = 32'(unsigned'(r_tri.bx));
            REG_VBY: prdata = 32'(unsigned'(r_tri.by));
            REG_VCX: prdata = 32'(unsigned'(r_tri.cx));
            REG_VCY: prdata = 32'(unsigned'(r_tri.cy));
            REG_COL: prdata = 32'(r_colour);
            default: prdata = '0;
        endcase
    end

    t_job front_job, queue_job;
    logic push, pop, full, empty;

    tss_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tri    (r_tri),
        .i_cfg_wr (wr),
        .i_valid  (s_axis_tvalid),
        .i_row    (s_axis_tdata[COORD_BITS-1:0]),
        .i_full   (full),
        .o_ready  (s_axis_tready),
        .o_push   (push),
        .o_job    (front_job)
    );

    tss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_full  (full),
        .o_empty (empty)
    );

    logic [COORD_BITS-1:0] span_x, span_row;
    logic [COORD_BITS:0]   span_width;
    logic [COLOUR_W-1:0]   span_colour;

    tss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_job         (queue_job),
        .o_pop         (pop),
        .i_colour      (r_colour),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_span_x      (span_x),
        .o_span_row    (span_row),
        .o_span_width  (span_width),
        .o_span_colour (span_colour)
    );

    assign m_axis_tdata = OUT_W'({span_colour, span_width, span_row, span_x});

endmodule

/* sv/tss_front.sv */
module tss_front
    import tss_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_tri                         i_tri,
    input  logic                         i_cfg_wr,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_row,
    input  logic                         i_full,
    output logic                         o_ready,
    output logic                         o_push,
    output t_job                         o_job
);

    logic signed [COORD_BITS-1:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic signed [COORD_BITS-1:0] n_x0, n_y0, n_x1, n_y1, n_x2, n_y2;
    logic signed [COORD_BITS-1:0] t;
    logic                         r_stale;

    // three compare-swaps on y, swap only when strictly greater
    always_comb begin
        t    = '0;
        n_x0 = i_tri.ax; n_y0 = i_tri.ay;
        n_x1 = i_tri.bx; n_y1 = i_tri.by;
        n_x2 = i_tri.cx; n_y2 = i_tri.cy;
        if (n_y0 > n_y1) begin
            t = n_y0; n_y0 = n_y1; n_y1 = t;
            t = n_x0; n_x0 = n_x1; n_x1 = t;
        end
        if (n_y1 > n_y2) begin
            t = n_y1; n_y1 = n_y2; n_y2 = t;
            t = n_x1; n_x1 = n_x2; n_x2 = t;
        end
        if (n_y0 > n_y1) begin
            t = n_y0; n_y0 = n_y1; n_y1 = t;
            t = n_x0; n_x0 = n_x1; n_x1 = t;
        end
    end

    // sorted vertices are registered and follow the registers in the next cycle
    always_ff @(posedge i_clk) begin
        r_x0 <= n_x0; r_y0 <= n_y0;
        r_x1 <= n_x1; r_y1 <= n_y1;
        r_x2 <= n_x2; r_y2 <= n_y2;
    end

    // hold off rows for one cycle while the sorted vertices catch up with a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale <= 1'b1;
        end else begin
            r_stale <= i_cfg_wr;
        end
    end

    logic signed [COORD_BITS:0] dx_a, dx_b, dr_a, dr_b, dy_a, dy_b;
    logic [COORD_BITS-1:0]      mag_a, mag_b;
    logic                       flat, upper, hit;
    logic signed [COORD_BITS-1:0] mn, mx;

    // classify the row and build the terms for edges a and b
    always_comb begin
        flat = (r_y0 == r_y2);
        if (flat) begin
            hit = (i_row == r_y0);
        end else begin
            hit = (i_row >= r_y0) && (i_row <= r_y2);
        end
        if (r_y1 == r_y2) begin
            upper = (i_row <= r_y1);
        end else begin
            upper = (i_row < r_y1);
        end
        mn = r_x0;
        mx = r_x0;
        if (r_x1 < mn) mn = r_x1;
        if (r_x1 > mx) mx = r_x1;
        if (r_x2 < mn) mn = r_x2;
        if (r_x2 > mx) mx = r_x2;

        dx_b = (COORD_BITS+1)'(r_x2) - (COORD_BITS+1)'(r_x0);
        dr_b = (COORD_BITS+1)'(i_row) - (COORD_BITS+1)'(r_y0);
        dy_b = (COORD_BITS+1)'(r_y2) - (COORD_BITS+1)'(r_y0);
        if (upper) begin
            dx_a = (COORD_BITS+1)'(r_x1) - (COORD_BITS+1)'(r_x0);
            dr_a = dr_b;
            dy_a = (COORD_BITS+1)'(r_y1) - (COORD_BITS+1)'(r_y0);
        end else begin
            dx_a = (COORD_BITS+1)'(r_x2) - (COORD_BITS+1)'(r_x1);
            dr_a = (COORD_BITS+1)'(i_row) - (COORD_BITS+1)'(r_y1);
            dy_a = (COORD_BITS+1)'(r_y2) - (COORD_BITS+1)'(r_y1);
        end
        mag_a = dx_a[COORD_BITS] ? COORD_BITS'(-dx_a) : dx_a[COORD_BITS-1:0];
        mag_b = dx_b[COORD_BITS] ? COORD_BITS'(-dx_b) : dx_b[COORD_BITS-1:0];

        o_job.row = i_row;
        if (flat) begin
            o_job.base_a = XW'(mn);
            o_job.base_b = XW'(mx);
            o_job.num_a  = '0;
            o_job.num_b  = '0;
            o_job.den_a  = COORD_BITS'(1);
            o_job.den_b  = COORD_BITS'(1);
            o_job.neg_a  = 1'b0;
            o_job.neg_b  = 1'b0;
        end else begin
            o_job.base_a = upper ? XW'(r_x0) : XW'(r_x1);
            o_job.base_b = XW'(r_x0);
            o_job.num_a  = NUM_W'(mag_a) * NUM_W'(dr_a[COORD_BITS-1:0]);
            o_job.num_b  = NUM_W'(mag_b) * NUM_W'(dr_b[COORD_BITS-1:0]);
            o_job.den_a  = dy_a[COORD_BITS-1:0];
            o_job.den_b  = dy_b[COORD_BITS-1:0];
            o_job.neg_a  = dx_a[COORD_BITS];
            o_job.neg_b  = dx_b[COORD_BITS];
        end
    end

    assign o_ready = !i_full && !r_stale;
    assign o_push  = i_valid && o_ready && hit;

endmodule

/* sv/tss_queue.sv */
module tss_queue
    import tss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job                   r_mem [2];
    logic                   r_wp, r_rp;
    logic [QUEUE_CNT_W-1:0] r_cnt;

    // two-entry job queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + QUEUE_CNT_W'(i_push) - QUEUE_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_job   = r_mem[r_rp];
    assign o_full  = (r_cnt == QUEUE_CNT_W'(2));
    assign o_empty = (r_cnt == '0);

endmodule

/* sv/tss_div.sv */
module tss_div
    import tss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic                  i_step,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [COORD_BITS-1:0] i_den,
    output logic [COORD_BITS-1:0] o_quo
);

    logic [NUM_W-1:0]      r_rq;
    logic [COORD_BITS-1:0] r_rem;
    logic [COORD_BITS-1:0] r_den;
    logic [COORD_BITS:0]   trial;
    logic                  fits;

    // restoring division, one quotient bit per step
    assign trial = {r_rem, r_rq[NUM_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (i_step) begin
            r_rq  <= {r_rq[NUM_W-2:0], fits};
            r_rem <= fits ? COORD_BITS'(trial - {1'b0, r_den}) : trial[COORD_BITS-1:0];
        end
    end

    assign o_quo = r_rq[COORD_BITS-1:0];

endmodule

/* sv/tss_back.sv */
module tss_back
    import tss_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  t_job                         i_job,
    output logic                         o_pop,
    input  logic [COLOUR_W-1:0]          i_colour,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [COORD_BITS-1:0]        o_span_x,
    output logic [COORD_BITS-1:0]        o_span_row,
    output logic [COORD_BITS:0]          o_span_width,
    output logic [COLOUR_W-1:0]          o_span_colour
);

    t_bstate               r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    t_job                  r_job;
    logic                  r_valid, n_valid;
    logic                  load, step, emit;
    logic [COORD_BITS-1:0] quo_a, quo_b;

    tss_div u_div_a (
        .i_clk  (i_clk),
        .i_load (load),
        .i_step (step),
        .i_num  (i_job.num_a),
        .i_den  (i_job.den_a),
        .o_quo  (quo_a)
    );

    tss_div u_div_b (
        .i_clk  (i_clk),
        .i_load (load),
        .i_step (step),
        .i_num  (i_job.num_b),
        .i_den  (i_job.den_b),
        .o_quo  (quo_b)
    );

    // sequencer: take a job, run both dividers, hand the span over
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        load    = 1'b0;
        step    = 1'b0;
        emit    = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    load    = 1'b1;
                    n_cnt   = CNT_W'(NUM_W);
                    n_state = B_DIV;
                end
            end
            B_DIV: begin
                step  = 1'b1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) n_state = B_DONE;
            end
            B_DONE: begin
                if (!r_valid || i_out_ready) begin
                    emit    = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
        n_valid = emit || (r_valid && !i_out_ready);
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_job <= i_job;
    end

    logic signed [XW-1:0] qa, qb, ea, eb, lo, hi, wid;

    // edges from the quotients, truncated toward zero by sign of the term
    always_comb begin
        qa  = r_job.neg_a ? -XW'(quo_a) : XW'(quo_a);
        qb  = r_job.neg_b ? -XW'(quo_b) : XW'(quo_b);
        ea  = r_job.base_a + qa;
        eb  = r_job.base_b + qb;
        lo  = (ea < eb) ? ea : eb;
        hi  = (ea < eb) ? eb : ea;
        wid = hi - lo + XW'(1);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_span_x      <= lo[COORD_BITS-1:0];
            o_span_row    <= r_job.row;
            o_span_width  <= wid[COORD_BITS:0];
            o_span_colour <= i_colour;
        end
    end

    assign o_out_valid = r_valid;

endmodule
